// ===== src/cbf_pkg.sv =====
// ============================================================================
// cbf_pkg
// Shared types and constants of the collision braking controller: field
// widths, register indexes, state codes and the level clamp.
// ============================================================================
package cbf_pkg;

	// Field widths
	localparam int DIST_W  = 17;
	localparam int SPD_W   = 8;
	localparam int TTC_W   = 4;
	localparam int THR_W   = 8;
	localparam int LVL_W   = 7;
	localparam int STATE_W = 2;
	localparam int PROD_W  = SPD_W + TTC_W;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRAKE_TTC     = 3'd0,
		REG_WARN_TTC      = 3'd1,
		REG_STABLE_THR    = 3'd2,
		REG_WARN_START    = 3'd3,
		REG_RAMP_STEP     = 3'd4,
		REG_RAMP_CAP      = 3'd5,
		REG_RELEASE_LEVEL = 3'd6
	} cbf_reg_t;

	localparam logic [LVL_W-1:0] FULL_LEVEL = 7'd100;
	localparam logic [LVL_W-1:0] ZERO_LEVEL = 7'd0;

	typedef enum logic [STATE_W-1:0] {
		CBF_SAFE  = 2'd0,
		CBF_WARN  = 2'd1,
		CBF_BRAKE = 2'd2
	} cbf_state_t;

	typedef struct packed {
		logic [TTC_W-1:0] brake_ttc_s;
		logic [TTC_W-1:0] warn_ttc_s;
		logic [THR_W-1:0] stable_threshold_cm;
		logic [LVL_W-1:0] warn_start_level;
		logic [LVL_W-1:0] ramp_step;
		logic [LVL_W-1:0] ramp_cap;
		logic [LVL_W-1:0] release_level;
	} cbf_cfg_t;

	typedef struct packed {
		cbf_state_t        fsm;
		logic [LVL_W-1:0]  level;
		logic [DIST_W-1:0] prev_distance;
	} cbf_ctx_t;

	// Saturate a level (up to one bit of growth) at 100 percent
	function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W:0] v);
		if (v > {1'b0, FULL_LEVEL})
			return FULL_LEVEL;
		return v[LVL_W-1:0];
	endfunction

endpackage

// ===== src/cbf_in_if.sv =====
// ============================================================================
// cbf_in_if
// Sample channel: one obstacle distance and vehicle speed per transaction.
// ============================================================================
interface cbf_in_if;
	import cbf_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance_cm;
	logic [SPD_W-1:0]  speed_cms;

	modport source (output valid, output distance_cm, output speed_cms, input ready);
	modport sink   (input valid, input distance_cm, input speed_cms, output ready);
endinterface

// ===== src/cbf_out_if.sv =====
// ============================================================================
// cbf_out_if
// Result channel: state, brake level and object flag per transaction.
// ============================================================================
interface cbf_out_if;
	import cbf_pkg::*;

	logic               valid;
	logic               ready;
	logic [STATE_W-1:0] collision_state;
	logic [LVL_W-1:0]   brake_level;
	logic               object_seen;

	modport source (output valid, output collision_state, output brake_level,
		output object_seen, input ready);
	modport sink   (input valid, input collision_state, input brake_level,
		input object_seen, output ready);
endinterface

// ===== src/cbf_decide.sv =====
// ============================================================================
// cbf_decide
// One tick of the controller: jitter filter, threat tests and the
// safe / warning / brake transition with its brake level.
// ============================================================================
module cbf_decide #(
	parameter int unsigned NO_OBSTACLE_CM = 100000
) (
	input  cbf_pkg::cbf_cfg_t                 cfg,
	input  cbf_pkg::cbf_ctx_t                 ctx,
	input  logic [cbf_pkg::DIST_W-1:0]        distance_cm,
	input  logic [cbf_pkg::SPD_W-1:0]         speed_cms,
	output cbf_pkg::cbf_ctx_t                 ctx_next,
	output logic                              object_seen
);
	import cbf_pkg::*;

	localparam logic [DIST_W-1:0] NO_OBST = DIST_W'(NO_OBSTACLE_CM);

	logic [DIST_W-1:0] diff;
	logic [DIST_W-1:0] dist_f;
	logic [PROD_W-1:0] brake_lim;
	logic [PROD_W-1:0] warn_lim;
	logic              threat_ok;
	logic              brake_thr;
	logic              warn_thr;

	// Hold the previous distance when the change is within the threshold
	always_comb begin
		if (distance_cm >= ctx.prev_distance)
			diff = distance_cm - ctx.prev_distance;
		else
			diff = ctx.prev_distance - distance_cm;
		if (diff <= {{(DIST_W-THR_W){1'b0}}, cfg.stable_threshold_cm})
			dist_f = ctx.prev_distance;
		else
			dist_f = distance_cm;
	end

	// ttc <= limit tested as distance <= speed * limit
	assign brake_lim   = PROD_W'(speed_cms) * PROD_W'(cfg.brake_ttc_s);
	assign warn_lim    = PROD_W'(speed_cms) * PROD_W'(cfg.warn_ttc_s);
	assign object_seen = dist_f < NO_OBST;
	assign threat_ok   = object_seen && (speed_cms != '0);
	assign brake_thr   = threat_ok && (dist_f <= {{(DIST_W-PROD_W){1'b0}}, brake_lim});
	assign warn_thr    = threat_ok && (dist_f <= {{(DIST_W-PROD_W){1'b0}}, warn_lim});

	always_comb begin
		ctx_next               = ctx;
		ctx_next.prev_distance = dist_f;
		case (ctx.fsm)
			CBF_WARN: begin
				if (!warn_thr) begin
					ctx_next.fsm   = CBF_SAFE;
					ctx_next.level = ZERO_LEVEL;
				end else if (brake_thr) begin
					ctx_next.fsm   = CBF_BRAKE;
					ctx_next.level = FULL_LEVEL;
				end else if (ctx.level < cfg.ramp_cap) begin
					ctx_next.level = clamp_level({1'b0, ctx.level} + {1'b0, cfg.ramp_step});
				end
			end
			CBF_BRAKE: begin
				if (!warn_thr) begin
					ctx_next.fsm   = CBF_SAFE;
					ctx_next.level = ZERO_LEVEL;
				end else if (!brake_thr) begin
					ctx_next.fsm   = CBF_WARN;
					ctx_next.level = clamp_level({1'b0, cfg.release_level});
				end else begin
					ctx_next.level = FULL_LEVEL;
				end
			end
			default: begin
				// safe, and the unused code treated as safe
				if (brake_thr) begin
					ctx_next.fsm   = CBF_BRAKE;
					ctx_next.level = FULL_LEVEL;
				end else if (warn_thr) begin
					ctx_next.fsm   = CBF_WARN;
					ctx_next.level = clamp_level({1'b0, cfg.warn_start_level});
				end else begin
					ctx_next.fsm   = CBF_SAFE;
					ctx_next.level = ZERO_LEVEL;
				end
			end
		endcase
	end

endmodule

// ===== src/collision_brake_fsm_unit.sv =====
// ============================================================================
// collision_brake_fsm_unit
// Forward collision braking controller: filters distance jitter, tests time
// to collision against brake and warning limits, and steps a three-state
// machine that sets the brake level.
// ============================================================================
//
//  channel    dir  handshake          payload
//  tick_in    in   valid / ready      distance_cm[16:0], speed_cms[7:0]
//  result_out out  valid / ready      collision_state[1:0], brake_level[6:0],
//                                     object_seen
//  cfg        in   cfg_we (no ready)  cfg_index[2:0], cfg_wdata[7:0]
//
//  Throughput is one transaction per cycle while result_out is not stalled.
//  result_out.valid rises once a sample has passed the input register and
//  then the result register; a result_out stall can hold it in between.
//  The controller state (filtered distance, FSM state, level) updates in the
//  same cycle a result is loaded, so back-to-back samples chain correctly.
//  result_out stalls back up through the input register: tick_in.ready stays
//  high as long as the input register is empty or moving forward this cycle.
//  arst_n clears the handshake flags, the controller state (safe, level 0,
//  previous distance at NO_OBSTACLE_CM) and the config registers to defaults.
// ============================================================================
module collision_brake_fsm_unit #(
	parameter int unsigned NO_OBSTACLE_CM = 100000
) (
	input  logic                             clk,
	input  logic                             arst_n,
	cbf_in_if.sink                           tick_in,
	cbf_out_if.source                        result_out,
	input  logic                             cfg_we,
	input  logic [cbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import cbf_pkg::*;

	// Configuration registers
	cbf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brake_ttc_s         <= 4'd1;
			cfg_q.warn_ttc_s          <= 4'd2;
			cfg_q.stable_threshold_cm <= 8'd1;
			cfg_q.warn_start_level    <= 7'd30;
			cfg_q.ramp_step           <= 7'd10;
			cfg_q.ramp_cap            <= 7'd80;
			cfg_q.release_level       <= 7'd50;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRAKE_TTC:     cfg_q.brake_ttc_s         <= cfg_wdata[TTC_W-1:0];
				REG_WARN_TTC:      cfg_q.warn_ttc_s          <= cfg_wdata[TTC_W-1:0];
				REG_STABLE_THR:    cfg_q.stable_threshold_cm <= cfg_wdata[THR_W-1:0];
				REG_WARN_START:    cfg_q.warn_start_level    <= cfg_wdata[LVL_W-1:0];
				REG_RAMP_STEP:     cfg_q.ramp_step           <= cfg_wdata[LVL_W-1:0];
				REG_RAMP_CAP:      cfg_q.ramp_cap            <= cfg_wdata[LVL_W-1:0];
				REG_RELEASE_LEVEL: cfg_q.release_level       <= cfg_wdata[LVL_W-1:0];
				default: ;  // index beyond the register list is dropped
			endcase
		end
	end

	// Input register (stage 1)
	logic              valid_s1;
	logic [DIST_W-1:0] distance_s1;
	logic [SPD_W-1:0]  speed_s1;

	// Result register
	logic               out_valid_q;
	logic [STATE_W-1:0] out_state_q;
	logic [LVL_W-1:0]   out_level_q;
	logic               out_obj_q;

	// Controller state carried from tick to tick
	cbf_ctx_t ctx_q;
	cbf_ctx_t ctx_next;
	logic     obj_next;

	logic advance;   // stage 1 moves into the result register
	logic take_in;   // input transaction accepted

	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign tick_in.ready = !valid_s1 || advance;
	assign take_in       = tick_in.valid && tick_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take_in)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			distance_s1 <= tick_in.distance_cm;
			speed_s1    <= tick_in.speed_cms;
		end
	end

	cbf_decide #(
		.NO_OBSTACLE_CM (NO_OBSTACLE_CM)
	) u_decide (
		.cfg         (cfg_q),
		.ctx         (ctx_q),
		.distance_cm (distance_s1),
		.speed_cms   (speed_s1),
		.ctx_next    (ctx_next),
		.object_seen (obj_next)
	);

	// FSM state, level and filtered distance advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.fsm           <= CBF_SAFE;
			ctx_q.level         <= ZERO_LEVEL;
			ctx_q.prev_distance <= DIST_W'(NO_OBSTACLE_CM);
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (result_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q <= ctx_next.fsm;
			out_level_q <= ctx_next.level;
			out_obj_q   <= obj_next;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.collision_state = out_state_q;
	assign result_out.brake_level     = out_level_q;
	assign result_out.object_seen     = out_obj_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------

	// Braking always reports full level
	a_brake_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_state_q == CBF_BRAKE) |-> out_level_q == FULL_LEVEL)
		else $error("brake state without full level");

	// Safe always reports released brakes
	a_safe_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_state_q == CBF_SAFE) |-> out_level_q == ZERO_LEVEL)
		else $error("safe state with nonzero level");

	// No object means no threat, hence safe
	a_no_obj_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_obj_q |-> out_state_q == CBF_SAFE)
		else $error("threat state reported without an object");

	// Stored controller level mirrors the last result
	a_ctx_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_level_q == ctx_q.level) && (out_state_q == ctx_q.fsm))
		else $error("result register differs from controller state");

	// A held sample in stage 1 stays there while the result is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(distance_s1) && $stable(speed_s1))
		else $error("stage 1 sample lost during stall");

endmodule

// ===== verif/collision_brake_fsm_unit_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// collision_brake_fsm_unit_test
// Self-checking bench for the collision braking controller. A directed table
// walks the state transitions and range extremes. Several register settings
// follow, each with approach runs mixed with noise. Every result transaction
// is compared with a typed row's hand-written expectation, or else with a
// behavioral predictor of the filter, threat tests and three-state machine.
// ============================================================================
module collision_brake_fsm_unit_test;
	import cbf_pkg::*;

	localparam int unsigned NO_OBSTACLE  = 100000;
	localparam int unsigned DIST_MAX     = (1 << DIST_W) - 1;
	localparam int          PHASE_TICKS  = 64;
	localparam int          CYCLE_LIMIT  = 200000;

	// One predicted result transaction
	typedef struct packed {
		cbf_state_t        state;
		logic [LVL_W-1:0]  level;
		logic              seen;
	} brake_result_t;

	// One sample; typed rows carry a hand-written expectation
	typedef struct packed {
		logic [DIST_W-1:0] dist_cm;
		logic [SPD_W-1:0]  spd;
		logic              typed;
		cbf_state_t        exp_state;
		logic [LVL_W-1:0]  exp_level;
		logic              exp_seen;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	cbf_in_if  tick_if ();
	cbf_out_if result_if ();

	collision_brake_fsm_unit #(
		.NO_OBSTACLE_CM (NO_OBSTACLE)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_in    (tick_if),
		.result_out (result_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state: register copies and the controller context
	// ------------------------------------------------------------------------
	logic [TTC_W-1:0]  m_brake_ttc;
	logic [TTC_W-1:0]  m_warn_ttc;
	logic [THR_W-1:0]  m_thr;
	logic [LVL_W-1:0]  m_start;
	logic [LVL_W-1:0]  m_step;
	logic [LVL_W-1:0]  m_cap;
	logic [LVL_W-1:0]  m_release;
	cbf_state_t        m_state;
	logic [LVL_W-1:0]  m_level;
	logic [DIST_W-1:0] m_prev;

	brake_result_t pending_results[$];
	int            error_count = 0;
	int            cycle_count = 0;
	bit            calm = 1'b0;   // no idling on either side while set

	// Approach run in progress (distance closing at a roughly fixed speed)
	int run_left = 0;
	int run_dist;
	int run_spd;
	int run_step;

	function automatic logic [LVL_W-1:0] sat_level(input int unsigned v);
		return (v > FULL_LEVEL) ? FULL_LEVEL : v[LVL_W-1:0];
	endfunction

	// Advance the controller by one sample and return its result
	function automatic brake_result_t predict_brake(input logic [DIST_W-1:0] d_raw,
		input logic [SPD_W-1:0] spd);
		int unsigned   d;
		int unsigned   diff;
		bit            obj;
		bit            brake_thr;
		bit            warn_thr;
		brake_result_t r;

		d    = 32'(d_raw);
		diff = (d >= m_prev) ? d - m_prev : m_prev - d;
		// jitter inside the threshold holds the last distance
		if (diff <= m_thr)
			d = m_prev;
		m_prev = d[DIST_W-1:0];

		obj       = d < NO_OBSTACLE;
		brake_thr = obj && spd != 0 && d <= int'(spd) * int'(m_brake_ttc);
		warn_thr  = obj && spd != 0 && d <= int'(spd) * int'(m_warn_ttc);

		case (m_state)
			CBF_WARN: begin
				if (!warn_thr) begin
					m_state = CBF_SAFE;
					m_level = ZERO_LEVEL;
				end else if (brake_thr) begin
					m_state = CBF_BRAKE;
					m_level = FULL_LEVEL;
				end else if (m_level < m_cap) begin
					m_level = sat_level(int'(m_level) + int'(m_step));
				end
			end
			CBF_BRAKE: begin
				if (!warn_thr) begin
					m_state = CBF_SAFE;
					m_level = ZERO_LEVEL;
				end else if (!brake_thr) begin
					m_state = CBF_WARN;
					m_level = sat_level(m_release);
				end else begin
					m_level = FULL_LEVEL;
				end
			end
			default: begin
				if (brake_thr) begin
					m_state = CBF_BRAKE;
					m_level = FULL_LEVEL;
				end else if (warn_thr) begin
					m_state = CBF_WARN;
					m_level = sat_level(m_start);
				end else begin
					m_state = CBF_SAFE;
					m_level = ZERO_LEVEL;
				end
			end
		endcase

		r.state = m_state;
		r.level = m_level;
		r.seen  = obj;
		return r;
	endfunction

	// Register write, called at a falling edge; leaves cfg_we high
	task automatic write_reg(input cbf_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			REG_BRAKE_TTC:     m_brake_ttc = val[TTC_W-1:0];
			REG_WARN_TTC:      m_warn_ttc  = val[TTC_W-1:0];
			REG_STABLE_THR:    m_thr       = val[THR_W-1:0];
			REG_WARN_START:    m_start     = val[LVL_W-1:0];
			REG_RAMP_STEP:     m_step      = val[LVL_W-1:0];
			REG_RAMP_CAP:      m_cap       = val[LVL_W-1:0];
			REG_RELEASE_LEVEL: m_release   = val[LVL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] brake_ttc,
		input logic [CFG_DATA_W-1:0] warn_ttc, input logic [CFG_DATA_W-1:0] thr,
		input logic [CFG_DATA_W-1:0] start, input logic [CFG_DATA_W-1:0] step,
		input logic [CFG_DATA_W-1:0] cap, input logic [CFG_DATA_W-1:0] rel);
		write_reg(REG_BRAKE_TTC, brake_ttc);
		write_reg(REG_WARN_TTC, warn_ttc);
		write_reg(REG_STABLE_THR, thr);
		write_reg(REG_WARN_START, start);
		write_reg(REG_RAMP_STEP, step);
		write_reg(REG_RAMP_CAP, cap);
		write_reg(REG_RELEASE_LEVEL, rel);
		cfg_we <= 1'b0;
	endtask

	// Send one sample transaction; called and returns at a falling edge
	task automatic send_tick(input tick_row_t row);
		brake_result_t predicted;
		while (!calm && $urandom_range(0, 99) < 22) begin
			tick_if.valid <= 1'b0;
			@(negedge clk);
		end
		tick_if.valid       <= 1'b1;
		tick_if.distance_cm <= row.dist_cm;
		tick_if.speed_cms   <= row.spd;
		do @(posedge clk); while (!tick_if.ready);
		// predictor always runs so its context tracks the block
		predicted = predict_brake(row.dist_cm, row.spd);
		if (row.typed)
			pending_results.push_back('{row.exp_state, row.exp_level, row.exp_seen});
		else
			pending_results.push_back(predicted);
		@(negedge clk);
	endtask

	// Wait for all results, then let the pipeline settle
	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly approach runs toward an obstacle, the rest noise
	task automatic pick_random_tick(output tick_row_t row);
		int d;
		int s;
		int span;
		int jit;
		row = '0;
		if ($urandom_range(0, 99) < 70) begin
			if (run_left == 0) begin
				run_spd  = $urandom_range(1, 255);
				span     = ((m_warn_ttc > m_brake_ttc) ? m_warn_ttc : m_brake_ttc) + 2;
				run_dist = run_spd * span + $urandom_range(0, 64);
				run_step = $urandom_range(1, run_spd / 2 + 1);
				run_left = $urandom_range(8, 40);
			end
			run_left--;
			case ($urandom_range(0, 9))
				0:       run_dist += $urandom_range(0, run_step * 2);   // backing off
				1:       run_dist += $urandom_range(0, m_thr);          // sensor jitter
				default: run_dist -= run_step;
			endcase
			if (run_dist < 0)
				run_dist = 0;
			d = run_dist;
			s = run_spd;
			if ($urandom_range(0, 9) == 0)
				s = $urandom_range(1, 255);
		end else begin
			if ($urandom_range(0, 3) == 0)
				run_left = 0;
			s = $urandom_range(0, 255);
			case ($urandom_range(0, 4))
				0: d = $urandom_range(0, DIST_MAX);
				1: d = $urandom_range(NO_OBSTACLE - 16, NO_OBSTACLE + 16);
				2: begin
					// right around the stored distance, across the threshold
					jit = $urandom_range(0, m_thr + 1);
					d   = $urandom_range(0, 1) ? int'(m_prev) + jit : int'(m_prev) - jit;
				end
				3: begin
					d = $urandom_range(0, 4000);
					s = 0;
				end
				default: begin
					d = $urandom_range(0, 1) ? DIST_MAX : 0;
					s = $urandom_range(0, 1) ? 255 : 1;
				end
			endcase
		end
		if (d < 0)
			d = 0;
		if (d > DIST_MAX)
			d = DIST_MAX;
		row.dist_cm = d[DIST_W-1:0];
		row.spd     = s[SPD_W-1:0];
	endtask

	// Directed rows, run at reset settings (brake 1 s, warn 2 s, threshold 1,
	// start 30, step 10, cap 80, release 50)
	tick_row_t directed_rows [22] = '{
		'{17'd100000, 8'd0,   1'b1, CBF_SAFE,  7'd0,   1'b0},  // hold at reset distance
		'{17'd0,      8'd255, 1'b1, CBF_BRAKE, 7'd100, 1'b1},  // zero distance, full speed
		'{17'd131071, 8'd255, 1'b1, CBF_SAFE,  7'd0,   1'b0},  // brake straight to safe
		'{17'd255,    8'd255, 1'b1, CBF_BRAKE, 7'd100, 1'b1},  // exactly on brake limit
		'{17'd510,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // brake back to warning
		'{17'd511,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // jitter, ramp
		'{17'd512,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // warning to safe
		'{17'd400,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // enter warning
		'{17'd402,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},
		'{17'd404,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},
		'{17'd406,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},
		'{17'd408,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},
		'{17'd410,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // ramp reaches cap
		'{17'd412,    8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // held at cap
		'{17'd200,    8'd255, 1'b1, CBF_BRAKE, 7'd100, 1'b1},  // warning to brake
		'{17'd300,    8'd0,   1'b1, CBF_SAFE,  7'd0,   1'b1},  // standing still
		'{17'd99999,  8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // just inside range
		'{17'd100000, 8'd255, 1'b0, CBF_SAFE,  7'd0,   1'b0},  // filter keeps it inside
		'{17'd100001, 8'd255, 1'b1, CBF_SAFE,  7'd0,   1'b0},
		'{17'd0,      8'd1,   1'b1, CBF_BRAKE, 7'd100, 1'b1},  // slowest speed
		'{17'd0,      8'd0,   1'b1, CBF_SAFE,  7'd0,   1'b1},
		'{17'd131071, 8'd0,   1'b1, CBF_SAFE,  7'd0,   1'b0}
	};

	// ------------------------------------------------------------------------
	// Result side: random back-pressure and the scoreboard compare
	// ------------------------------------------------------------------------
	always @(negedge clk)
		result_if.ready <= calm || ($urandom_range(0, 99) >= 22);

	always @(posedge clk) begin
		brake_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_if.collision_state !== want.state) begin
					$error("collision_state: expected %0d, got %0d",
						want.state, result_if.collision_state);
					error_count++;
				end
				if (result_if.brake_level !== want.level) begin
					$error("brake_level: expected %0d, got %0d",
						want.level, result_if.brake_level);
					error_count++;
				end
				if (result_if.object_seen !== want.seen) begin
					$error("object_seen: expected %0d, got %0d",
						want.seen, result_if.object_seen);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("collision_brake_fsm_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		tick_row_t row;

		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_BRAKE_TTC;
		cfg_wdata           = '0;
		tick_if.valid       = 1'b0;
		tick_if.distance_cm = '0;
		tick_if.speed_cms   = '0;
		result_if.ready     = 1'b0;

		// predictor mirrors the reset state
		m_brake_ttc = 4'd1;
		m_warn_ttc  = 4'd2;
		m_thr       = 8'd1;
		m_start     = 7'd30;
		m_step      = 7'd10;
		m_cap       = 7'd80;
		m_release   = 7'd50;
		m_state     = CBF_SAFE;
		m_level     = ZERO_LEVEL;
		m_prev      = DIST_W'(NO_OBSTACLE);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_tick(directed_rows[i]);
		tick_if.valid <= 1'b0;

		// Register phases; each waits for the block to go idle first
		for (int phase = 0; phase < 7; phase++) begin
			drain();
			case (phase)
				0: apply_settings(1, 3, 2, 30, 10, 80, 50);
				1: apply_settings(0, 0, 0, 0, 0, 0, 0);
				2: apply_settings(15, 15, 255, 127, 127, 127, 127);   // levels clamp
				3: apply_settings(9, 4, 6, 100, 100, 100, 100);      // brake limit > warn
				4: apply_settings(2, 12, 3, 5, 7, 100, 100);         // long ramp
				default: apply_settings(CFG_DATA_W'($urandom_range(0, 255)),
					CFG_DATA_W'($urandom_range(0, 255)),
					CFG_DATA_W'($urandom_range(0, 255)),
					CFG_DATA_W'($urandom_range(0, 255)),
					CFG_DATA_W'($urandom_range(0, 255)),
					CFG_DATA_W'($urandom_range(0, 255)),
					CFG_DATA_W'($urandom_range(0, 255)));
			endcase
			@(negedge clk);
			run_left = 0;
			calm     = (phase == 3);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				pick_random_tick(row);
				send_tick(row);
			end
			tick_if.valid <= 1'b0;
			calm = 1'b0;
		end

		drain();
		if (error_count == 0 && pending_results.size() == 0)
			$display("collision_brake_fsm_unit: match");
		else
			$display("collision_brake_fsm_unit: mismatch");
		$finish;
	end

endmodule
